@@ rtl/befr_pkg.sv @@
// ----------------------------------------------------------------------------
// befr_pkg
// Shared types and constants of the binned efficiency ratio factor unit.
// ----------------------------------------------------------------------------
package befr_pkg;

   localparam int PT_W    = 17;
   localparam int ETA_W   = 14;
   localparam int EFF_W   = 17;
   localparam int OUT_W   = 24;
   localparam int SHIFT_W = 28;
   localparam int STAT_W  = 3;
   localparam int SYST_W  = 4;
   localparam int EMODE_W = 2;

   localparam int NUM_W  = 53;
   localparam int DEN_W  = 34;
   localparam int QUO_W  = 29;
   localparam int ROOT_W = 29;
   localparam int RAD_W  = 58;
   localparam int OPND_W = 29;
   localparam int PROD_W = 58;
   localparam int KEY_W  = 62;

   localparam logic [EFF_W-1:0] ONE_Q16 = 17'h10000;
   localparam logic [OUT_W-1:0] MAX24   = 24'hFFFFFF;
   localparam logic [QUO_W-1:0] CAP28   = 29'h1000_0000;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   localparam logic [EMODE_W-1:0] ERR_LINEAR = 2'd0;
   localparam logic [EMODE_W-1:0] ERR_DATA   = 2'd1;
   localparam logic [EMODE_W-1:0] ERR_QUAD   = 2'd2;

   localparam logic [1:0] CSR_VETO  = 2'd0;
   localparam logic [1:0] CSR_EMODE = 2'd1;
   localparam logic [1:0] CSR_SYST  = 2'd2;

   typedef enum logic [STAT_W-1:0] {
      RES_HIT      = 3'd0,
      RES_INSERTED = 3'd1,
      RES_MISS     = 3'd2,
      RES_FULL     = 3'd3,
      RES_DIV0     = 3'd4
   } res_code_type;

   typedef enum logic [2:0] {
      DIV_SF,
      DIV_ERD,
      DIV_ERL,
      DIV_E1,
      DIV_E2
   } div_sel_type;

   typedef enum logic [2:0] {
      MUL_BB,
      MUL_AEB,
      MUL_EAB,
      MUL_E1SQ,
      MUL_E2SQ
   } mul_op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SCAN,
      ST_INSERT,
      ST_PREP,
      ST_MUL_BB,
      ST_MUL_AEB,
      ST_MUL_EAB,
      ST_SF_GO,
      ST_SF_WAIT,
      ST_ER_GO,
      ST_ER_WAIT,
      ST_E2_GO,
      ST_E2_WAIT,
      ST_SQ1,
      ST_SQ2,
      ST_RT_GO,
      ST_RT_WAIT,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic [PT_W-1:0]  pt_low;
      logic [PT_W-1:0]  pt_high;
      logic [ETA_W-1:0] eta_low;
      logic [ETA_W-1:0] eta_high;
      logic [EFF_W-1:0] data_eff;
      logic [EFF_W-1:0] data_err;
      logic [EFF_W-1:0] mc_eff;
      logic [EFF_W-1:0] mc_err;
   } entry_type;

   typedef struct packed {
      logic             action;
      entry_type        bin;
      logic [PT_W-1:0]  query_pt;
      logic [ETA_W-1:0] query_eta;
   } req_type;

   typedef struct packed {
      logic         capture;
      logic         scan_run;
      logic         ins_commit;
      logic         prep;
      logic         mul_en;
      mul_op_type   mul_op;
      logic         div_start;
      div_sel_type  div_sel;
      logic         rt_start;
      logic         set_res;
      res_code_type res_code;
      logic         res_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic               is_lookup;
      logic               scan_done;
      logic               hit;
      logic               full;
      logic               b_zero;
      logic [EMODE_W-1:0] error_mode;
      logic               div_done;
      logic               rt_done;
      logic               out_free;
   } ctrl_status_type;

endpackage

@@ rtl/befr_if.sv @@
// ----------------------------------------------------------------------------
// befr_if
// Request and response channels of the ratio factor unit.
// ----------------------------------------------------------------------------
interface befr_req_if import befr_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             action;
   logic [PT_W-1:0]  pt_low;
   logic [PT_W-1:0]  pt_high;
   logic [ETA_W-1:0] eta_low;
   logic [ETA_W-1:0] eta_high;
   logic [EFF_W-1:0] data_eff;
   logic [EFF_W-1:0] data_err;
   logic [EFF_W-1:0] mc_eff;
   logic [EFF_W-1:0] mc_err;
   logic [PT_W-1:0]  query_pt;
   logic [ETA_W-1:0] query_eta;

   modport source (output valid, action, pt_low, pt_high, eta_low, eta_high, data_eff,
                   data_err, mc_eff, mc_err, query_pt, query_eta, input ready);
   modport sink (input valid, action, pt_low, pt_high, eta_low, eta_high, data_eff,
                 data_err, mc_eff, mc_err, query_pt, query_eta, output ready);
endinterface

interface befr_rsp_if import befr_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [STAT_W-1:0]         status;
   logic [OUT_W-1:0]          scale_factor;
   logic [OUT_W-1:0]          scale_error;
   logic signed [SHIFT_W-1:0] shifted_factor;

   modport source (output valid, status, scale_factor, scale_error, shifted_factor,
                   input ready);
   modport sink (input valid, status, scale_factor, scale_error, shifted_factor,
                 output ready);
endinterface

@@ rtl/befr_divider.sv @@
// ----------------------------------------------------------------------------
// befr_divider
// Restoring divider, one quotient bit per cycle, with overflow detect.
// ----------------------------------------------------------------------------
module befr_divider import befr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic             ovf,
   output logic [QUO_W-1:0] quot
);

   localparam int CNT_W = $clog2(QUO_W + 1);
   localparam int HI_W  = NUM_W - QUO_W;

   logic             run_ff;
   logic             done_ff;
   logic             ovf_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [QUO_W-1:0] lo_ff;
   logic [QUO_W-1:0] quot_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   trial;
   logic             take;

   assign trial = {rem_ff, lo_ff[QUO_W-1]};
   assign take  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= run_ff && (cnt_ff == CNT_W'(1));
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CNT_W'(QUO_W);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ovf_ff  <= DEN_W'(num[NUM_W-1:QUO_W]) >= den;
         rem_ff  <= DEN_W'(num[NUM_W-1:NUM_W-HI_W]);
         lo_ff   <= num[QUO_W-1:0];
         den_ff  <= den;
         quot_ff <= '0;
      end else if (run_ff) begin
         rem_ff  <= take ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         lo_ff   <= {lo_ff[QUO_W-2:0], 1'b0};
         quot_ff <= {quot_ff[QUO_W-2:0], take};
      end
   end

   assign done = done_ff;
   assign ovf  = ovf_ff;
   assign quot = quot_ff;

endmodule

@@ rtl/befr_isqrt.sv @@
// ----------------------------------------------------------------------------
// befr_isqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module befr_isqrt import befr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAD_W-1:0]  radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   localparam int CNT_W = $clog2(ROOT_W + 1);
   localparam int REM_W = ROOT_W + 2;

   logic              run_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [RAD_W-1:0]  x_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [REM_W+1:0]  rem_in;
   logic [REM_W+1:0]  trial;
   logic              take;

   assign rem_in = {rem_ff, x_ff[RAD_W-1:RAD_W-2]};
   assign trial  = (REM_W + 2)'({root_ff, 2'b01});
   assign take   = rem_in >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= run_ff && (cnt_ff == CNT_W'(1));
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CNT_W'(ROOT_W);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (run_ff) begin
         x_ff    <= {x_ff[RAD_W-3:0], 2'b00};
         rem_ff  <= take ? REM_W'(rem_in - trial) : rem_in[REM_W-1:0];
         root_ff <= {root_ff[ROOT_W-2:0], take};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

@@ rtl/befr_datapath.sv @@
// ----------------------------------------------------------------------------
// befr_datapath
// Bin table, scan compare, shared multiplier, divider, square root, result.
// ----------------------------------------------------------------------------
module befr_datapath import befr_pkg::*; #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ctrl_cmd_type              cmd,
   output ctrl_status_type           sts,
   input  req_type                   req_data,
   input  logic                      veto_mode,
   input  logic [EMODE_W-1:0]        error_mode,
   input  logic [SYST_W-1:0]         syst_shift,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [STAT_W-1:0]         out_status,
   output logic [OUT_W-1:0]          out_factor,
   output logic [OUT_W-1:0]          out_error,
   output logic signed [SHIFT_W-1:0] out_shifted
);

   localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   function automatic logic [KEY_W-1:0] bin_key(entry_type e);
      bin_key = {e.pt_low, e.pt_high, ~e.eta_low[ETA_W-1], e.eta_low[ETA_W-2:0],
                 ~e.eta_high[ETA_W-1], e.eta_high[ETA_W-2:0]};
   endfunction

   function automatic logic [EFF_W-1:0] clamp1(logic [EFF_W-1:0] v);
      clamp1 = (v > ONE_Q16) ? ONE_Q16 : v;
   endfunction

   entry_type mem [TABLE_ENTRIES];

   req_type      req_ff;
   entry_type    rd_ff;
   entry_type    best_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  scan_idx_ff;
   logic              pend_ff;
   logic [ADDR_W-1:0] pend_idx_ff;
   logic              found_ff;
   logic [ADDR_W-1:0] found_idx_ff;

   logic [EFF_W-1:0] a_ff, b_ff, ea_ff, eb_ff;
   logic [32:0]      bb_ff, aeb_ff, eab_ff;
   logic [QUO_W-1:0] e1_ff, e2_ff;
   logic [56:0]      e1sq_ff, e2sq_ff;
   logic [OUT_W-1:0] sf_ff, er_ff;
   res_code_type     code_ff;
   div_sel_type      div_sel_ff;

   logic                      out_valid_ff;
   logic [STAT_W-1:0]         out_status_ff;
   logic [OUT_W-1:0]          out_factor_ff;
   logic [OUT_W-1:0]          out_error_ff;
   logic signed [SHIFT_W-1:0] out_shifted_ff;

   logic             full;
   logic             scan_more;
   logic             contains;
   logic             same;
   logic             wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [EFF_W-1:0] de_c, me_c, a_in, b_in;
   logic [OPND_W-1:0] op_x, op_y;
   logic [PROD_W-1:0] prod;
   logic [NUM_W-1:0] div_num;
   logic [DEN_W-1:0] div_den;
   logic             div_done, div_ovf;
   logic [QUO_W-1:0] div_quot;
   logic             rt_done;
   logic [ROOT_W-1:0] rt_root;
   logic [ROOT_W:0]  rt_round;
   logic [33:0]      lin_sum;
   logic [OUT_W-1:0] q_sat24;
   logic [QUO_W-1:0] q_cap28;
   logic signed [SHIFT_W-1:0] shifted_in;

   // ---- table scan ----
   assign full      = !found_ff && (count_ff == CNT_W'(TABLE_ENTRIES));
   assign scan_more = scan_idx_ff < count_ff;

   assign contains = (req_ff.query_pt >= rd_ff.pt_low) && (req_ff.query_pt < rd_ff.pt_high)
                     && ($signed(req_ff.query_eta) >= $signed(rd_ff.eta_low))
                     && ($signed(req_ff.query_eta) < $signed(rd_ff.eta_high));
   assign same = bin_key(rd_ff) == bin_key(req_ff.bin);

   always_ff @(posedge clock) begin
      rd_ff <= mem[scan_idx_ff[ADDR_W-1:0]];
   end

   assign wr_en   = cmd.ins_commit && !full;
   assign wr_addr = found_ff ? found_idx_ff : count_ff[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_ff.bin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         scan_idx_ff <= '0;
         pend_ff     <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         if (cmd.capture) begin
            scan_idx_ff <= '0;
            pend_ff     <= 1'b0;
            found_ff    <= 1'b0;
         end else if (cmd.scan_run) begin
            pend_ff <= scan_more;
            if (scan_more) begin
               scan_idx_ff <= scan_idx_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               if (req_ff.action == ACT_LOOKUP) begin
                  if (contains && (!found_ff || bin_key(rd_ff) < bin_key(best_ff))) begin
                     found_ff <= 1'b1;
                  end
               end else if (same && !found_ff) begin
                  found_ff <= 1'b1;
               end
            end
         end
         if (wr_en && !found_ff) begin
            count_ff <= count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.scan_run) begin
         pend_idx_ff <= scan_idx_ff[ADDR_W-1:0];
         if (pend_ff) begin
            if (req_ff.action == ACT_LOOKUP) begin
               if (contains && (!found_ff || bin_key(rd_ff) < bin_key(best_ff))) begin
                  best_ff      <= rd_ff;
                  found_idx_ff <= pend_idx_ff;
               end
            end else if (same && !found_ff) begin
               found_idx_ff <= pend_idx_ff;
            end
         end
      end
   end

   // ---- operands ----
   assign de_c = clamp1(best_ff.data_eff);
   assign me_c = clamp1(best_ff.mc_eff);
   assign a_in = veto_mode ? ONE_Q16 - de_c : de_c;
   assign b_in = veto_mode ? ONE_Q16 - me_c : me_c;

   always_comb begin
      op_x = OPND_W'(b_ff);
      op_y = OPND_W'(b_ff);
      case (cmd.mul_op)
         MUL_BB: begin
            op_x = OPND_W'(b_ff);
            op_y = OPND_W'(b_ff);
         end
         MUL_AEB: begin
            op_x = OPND_W'(a_ff);
            op_y = OPND_W'(eb_ff);
         end
         MUL_EAB: begin
            op_x = OPND_W'(ea_ff);
            op_y = OPND_W'(b_ff);
         end
         MUL_E1SQ: begin
            op_x = e1_ff;
            op_y = e1_ff;
         end
         MUL_E2SQ: begin
            op_x = e2_ff;
            op_y = e2_ff;
         end
         default: begin
            op_x = OPND_W'(b_ff);
            op_y = OPND_W'(b_ff);
         end
      endcase
   end

   assign prod = op_x * op_y;

   // ---- divider operands ----
   assign lin_sum = {1'b0, eab_ff} + {1'b0, aeb_ff};

   always_comb begin
      div_num = NUM_W'({a_ff, 17'b0}) + NUM_W'(b_ff);
      div_den = DEN_W'({b_ff, 1'b0});
      case (cmd.div_sel)
         DIV_SF: begin
            div_num = NUM_W'({a_ff, 17'b0}) + NUM_W'(b_ff);
            div_den = DEN_W'({b_ff, 1'b0});
         end
         DIV_ERD: begin
            div_num = NUM_W'({ea_ff, 17'b0}) + NUM_W'(b_ff);
            div_den = DEN_W'({b_ff, 1'b0});
         end
         DIV_ERL: begin
            div_num = NUM_W'({lin_sum, 17'b0}) + NUM_W'(bb_ff);
            div_den = DEN_W'({bb_ff, 1'b0});
         end
         DIV_E1: begin
            div_num = NUM_W'({ea_ff, 20'b0});
            div_den = DEN_W'(b_ff);
         end
         DIV_E2: begin
            div_num = NUM_W'({aeb_ff, 20'b0});
            div_den = DEN_W'(bb_ff);
         end
         default: begin
            div_num = NUM_W'({a_ff, 17'b0}) + NUM_W'(b_ff);
            div_den = DEN_W'({b_ff, 1'b0});
         end
      endcase
   end

   befr_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .ovf   (div_ovf),
      .quot  (div_quot)
   );

   befr_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.rt_start),
      .radicand (RAD_W'(e1sq_ff) + RAD_W'(e2sq_ff)),
      .done     (rt_done),
      .root     (rt_root)
   );

   assign q_sat24  = (div_ovf || div_quot[QUO_W-1:OUT_W] != '0) ? MAX24 : div_quot[OUT_W-1:0];
   assign q_cap28  = (div_ovf || div_quot > CAP28) ? CAP28 : div_quot;
   assign rt_round = {1'b0, rt_root} + (ROOT_W + 1)'(8);

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         a_ff  <= a_in;
         b_ff  <= b_in;
         ea_ff <= clamp1(best_ff.data_err);
         eb_ff <= clamp1(best_ff.mc_err);
      end
      if (cmd.mul_en) begin
         case (cmd.mul_op)
            MUL_BB:   bb_ff   <= prod[32:0];
            MUL_AEB:  aeb_ff  <= prod[32:0];
            MUL_EAB:  eab_ff  <= prod[32:0];
            MUL_E1SQ: e1sq_ff <= prod[56:0];
            MUL_E2SQ: e2sq_ff <= prod[56:0];
            default:  bb_ff   <= prod[32:0];
         endcase
      end
      if (cmd.div_start) begin
         div_sel_ff <= cmd.div_sel;
      end
      if (div_done) begin
         case (div_sel_ff)
            DIV_SF:  sf_ff <= q_sat24;
            DIV_ERD: er_ff <= q_sat24;
            DIV_ERL: er_ff <= q_sat24;
            DIV_E1:  e1_ff <= q_cap28;
            DIV_E2:  e2_ff <= q_cap28;
            default: sf_ff <= q_sat24;
         endcase
      end
      if (rt_done) begin
         er_ff <= (rt_round[ROOT_W:28] != '0) ? MAX24 : rt_round[27:4];
      end
      if (cmd.set_res) begin
         code_ff <= cmd.res_code;
         case (cmd.res_code)
            RES_INSERTED, RES_FULL: begin
               sf_ff <= '0;
               er_ff <= '0;
            end
            RES_MISS: begin
               sf_ff <= OUT_W'(ONE_Q16);
               er_ff <= '0;
            end
            RES_DIV0: begin
               sf_ff <= MAX24;
               er_ff <= MAX24;
            end
            default: begin
               sf_ff <= sf_ff;
            end
         endcase
      end
   end

   // ---- result register ----
   assign shifted_in = $signed({4'b0, sf_ff})
                       + $signed({4'b0, er_ff}) * $signed({{24{syst_shift[SYST_W-1]}}, syst_shift});

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.res_load) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         out_status_ff <= code_ff;
         out_factor_ff <= sf_ff;
         out_error_ff  <= er_ff;
         out_shifted_ff <= (code_ff == RES_INSERTED || code_ff == RES_FULL) ? '0 : shifted_in;
      end
   end

   assign out_valid   = out_valid_ff;
   assign out_status  = out_status_ff;
   assign out_factor  = out_factor_ff;
   assign out_error   = out_error_ff;
   assign out_shifted = out_shifted_ff;

   assign sts.is_lookup  = req_ff.action == ACT_LOOKUP;
   assign sts.scan_done  = !scan_more && !pend_ff;
   assign sts.hit        = found_ff;
   assign sts.full       = full;
   assign sts.b_zero     = b_in == '0;
   assign sts.error_mode = error_mode;
   assign sts.div_done   = div_done;
   assign sts.rt_done    = rt_done;
   assign sts.out_free   = !out_valid_ff || out_ready;

endmodule

@@ rtl/befr_ctrl.sv @@
// ----------------------------------------------------------------------------
// befr_ctrl
// Sequencer for table scan, insert and the factor and error arithmetic.
// ----------------------------------------------------------------------------
module befr_ctrl import befr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ctrl_status_type sts,
   output ctrl_cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_SCAN;
         ST_SCAN: begin
            if (sts.scan_done) begin
               if (!sts.is_lookup) state_in = ST_INSERT;
               else if (sts.hit)   state_in = ST_PREP;
               else                state_in = ST_RESULT;
            end
         end
         ST_INSERT:  state_in = ST_RESULT;
         ST_PREP:    state_in = sts.b_zero ? ST_RESULT : ST_MUL_BB;
         ST_MUL_BB:  state_in = ST_MUL_AEB;
         ST_MUL_AEB: state_in = ST_MUL_EAB;
         ST_MUL_EAB: state_in = ST_SF_GO;
         ST_SF_GO:   state_in = ST_SF_WAIT;
         ST_SF_WAIT: if (sts.div_done) state_in = ST_ER_GO;
         ST_ER_GO:   state_in = ST_ER_WAIT;
         ST_ER_WAIT: begin
            if (sts.div_done) begin
               state_in = (sts.error_mode == ERR_QUAD) ? ST_E2_GO : ST_RESULT;
            end
         end
         ST_E2_GO:   state_in = ST_E2_WAIT;
         ST_E2_WAIT: if (sts.div_done) state_in = ST_SQ1;
         ST_SQ1:     state_in = ST_SQ2;
         ST_SQ2:     state_in = ST_RT_GO;
         ST_RT_GO:   state_in = ST_RT_WAIT;
         ST_RT_WAIT: if (sts.rt_done) state_in = ST_RESULT;
         ST_RESULT:  if (sts.out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_done && sts.is_lookup && !sts.hit) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = RES_MISS;
            end
         end
         ST_INSERT: begin
            cmd.ins_commit = 1'b1;
            cmd.set_res    = 1'b1;
            cmd.res_code   = sts.full ? RES_FULL : RES_INSERTED;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            if (sts.b_zero) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = RES_DIV0;
            end
         end
         ST_MUL_BB: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_BB;
         end
         ST_MUL_AEB: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_AEB;
         end
         ST_MUL_EAB: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_EAB;
         end
         ST_SF_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SF;
         end
         ST_ER_GO: begin
            cmd.div_start = 1'b1;
            if (sts.error_mode == ERR_DATA)      cmd.div_sel = DIV_ERD;
            else if (sts.error_mode == ERR_QUAD) cmd.div_sel = DIV_E1;
            else                                 cmd.div_sel = DIV_ERL;
         end
         ST_ER_WAIT: begin
            if (sts.div_done && sts.error_mode != ERR_QUAD) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = RES_HIT;
            end
         end
         ST_E2_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_E2;
         end
         ST_SQ1: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_E1SQ;
         end
         ST_SQ2: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_E2SQ;
         end
         ST_RT_GO: begin
            cmd.rt_start = 1'b1;
         end
         ST_RT_WAIT: begin
            if (sts.rt_done) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = RES_HIT;
            end
         end
         ST_RESULT: begin
            cmd.res_load = sts.out_free;
         end
         ST_SF_WAIT, ST_E2_WAIT: begin
            cmd.scan_run = 1'b0;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ rtl/binned_efficiency_ratio_factor_unit.sv @@
// ----------------------------------------------------------------------------
// binned_efficiency_ratio_factor_unit
// Binned data/simulation efficiency ratio with error propagation.
//
//   channel   kind             handshake
//   req_if    item in          valid/ready
//   rsp_if    item out         valid/ready, output register
//   csr_*     register access  APB-style, pready tied high
//
// Insert: a table scan, one table entry read per cycle, then the write.
// Lookup: the scan, then the divisions and, in quadrature mode, the squares
// and the square root; each division and the square root run in one-bit-per-cycle units.
// Synchronous reset empties the table at once through the fill count.
// One item at a time; the finished item waits in the output register.
// ----------------------------------------------------------------------------
module binned_efficiency_ratio_factor_unit import befr_pkg::*; #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   befr_req_if.sink    req_if,
   befr_rsp_if.source  rsp_if,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic               veto_ff;
   logic [EMODE_W-1:0] emode_ff;
   logic [SYST_W-1:0]  syst_ff;
   logic               csr_wr;
   logic [1:0]         csr_idx;
   ctrl_cmd_type       cmd;
   ctrl_status_type    sts;
   req_type            req_data;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         veto_ff  <= 1'b0;
         emode_ff <= ERR_LINEAR;
         syst_ff  <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_VETO:  veto_ff  <= csr_pwdata[0];
            CSR_EMODE: emode_ff <= csr_pwdata[EMODE_W-1:0];
            CSR_SYST:  syst_ff  <= csr_pwdata[SYST_W-1:0];
            default:   veto_ff  <= veto_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_VETO:  csr_prdata = {31'b0, veto_ff};
         CSR_EMODE: csr_prdata = {30'b0, emode_ff};
         CSR_SYST:  csr_prdata = {28'b0, syst_ff};
         default:   csr_prdata = '0;
      endcase
   end

   assign req_data.action        = req_if.action;
   assign req_data.bin.pt_low    = req_if.pt_low;
   assign req_data.bin.pt_high   = req_if.pt_high;
   assign req_data.bin.eta_low   = req_if.eta_low;
   assign req_data.bin.eta_high  = req_if.eta_high;
   assign req_data.bin.data_eff  = req_if.data_eff;
   assign req_data.bin.data_err  = req_if.data_err;
   assign req_data.bin.mc_eff    = req_if.mc_eff;
   assign req_data.bin.mc_err    = req_if.mc_err;
   assign req_data.query_pt      = req_if.query_pt;
   assign req_data.query_eta     = req_if.query_eta;

   befr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   befr_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_data    (req_data),
      .veto_mode   (veto_ff),
      .error_mode  (emode_ff),
      .syst_shift  (syst_ff),
      .out_valid   (rsp_if.valid),
      .out_ready   (rsp_if.ready),
      .out_status  (rsp_if.status),
      .out_factor  (rsp_if.scale_factor),
      .out_error   (rsp_if.scale_error),
      .out_shifted (rsp_if.shifted_factor)
   );

endmodule

@@ rtl/befr_checker.sv @@
// ----------------------------------------------------------------------------
// befr_checker
// Port-level checks on the ratio factor unit, bound to the top level.
// ----------------------------------------------------------------------------
module befr_checker import befr_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [STAT_W-1:0]         rsp_status,
   input logic [OUT_W-1:0]          rsp_factor,
   input logic [OUT_W-1:0]          rsp_error,
   input logic signed [SHIFT_W-1:0] rsp_shifted
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while one is in work");

   a_insert_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == RES_INSERTED || rsp_status == RES_FULL) |->
      rsp_factor == '0 && rsp_error == '0 && rsp_shifted == '0)
      else $error("insert result carries nonzero values");

   a_miss_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == RES_MISS |->
      rsp_factor == OUT_W'(ONE_Q16) && rsp_error == '0
      && rsp_shifted == SHIFT_W'(ONE_Q16))
      else $error("miss result is not unity");

   a_div0_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == RES_DIV0 |-> rsp_factor == MAX24 && rsp_error == MAX24)
      else $error("zero denominator not saturated");

endmodule

bind binned_efficiency_ratio_factor_unit befr_checker u_befr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_status  (rsp_if.status),
   .rsp_factor  (rsp_if.scale_factor),
   .rsp_error   (rsp_if.scale_error),
   .rsp_shifted (rsp_if.shifted_factor)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the binned efficiency ratio factor unit. A short
// table of directed items (empty table, extreme bounds and values, overwrite,
// zero denominator, no bin) is followed by random phases under several
// register settings. Every response is checked against its directed value or a
// model of the bin table kept in this bench, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   import befr_pkg::*;

   localparam int NBINS     = 64;
   localparam int LIMIT     = 3_000_000;
   localparam int DRAIN     = 300;
   localparam int RAND_ITEMS = 140;

   typedef struct {
      logic [STAT_W-1:0]  status;
      logic [OUT_W-1:0]   sf;
      logic [OUT_W-1:0]   er;
      logic [SHIFT_W-1:0] sh;
   } factor_type;

   typedef struct {
      req_type    r;
      bit         typed;
      factor_type e;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [3:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   befr_req_if req_if ();
   befr_rsp_if rsp_if ();

   binned_efficiency_ratio_factor_unit dut (
      .clock(clock), .reset(reset), .req_if(req_if.sink), .rsp_if(rsp_if.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #4 clock = ~clock;

   // bin table model
   bit                bin_valid [NBINS];
   entry_type         bin_tab [NBINS];
   int                bin_fill;
   bit                m_veto;
   logic [1:0]        m_emode;
   int                m_syst;

   factor_type        factor_q[$];
   int                errors;
   int                cycles;
   bit                idle_on = 1;
   bit                long_hold = 0;

   function automatic bit bounds_less(entry_type x, entry_type y);
      if (x.pt_low != y.pt_low) return x.pt_low < y.pt_low;
      if (x.pt_high != y.pt_high) return x.pt_high < y.pt_high;
      if (x.eta_low != y.eta_low) return $signed(x.eta_low) < $signed(y.eta_low);
      return $signed(x.eta_high) < $signed(y.eta_high);
   endfunction

   function automatic longint unsigned clamp_one(logic [EFF_W-1:0] v);
      return (v > ONE_Q16) ? 64'd65536 : 64'(v);
   endfunction

   function automatic longint unsigned sat_out(longint unsigned v);
      return (v > 64'hFFFFFF) ? 64'hFFFFFF : v;
   endfunction

   function automatic longint unsigned round_div(longint unsigned n, longint unsigned d);
      return (2 * n + d) / (2 * d);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic factor_type compute_factor(req_type q);
      factor_type o;
      int slot, hit;
      longint unsigned de, ea, me, eb, a, b, sf, er, e1, e2, cap;
      longint sh;
      o = '{status: RES_INSERTED, sf: '0, er: '0, sh: '0};
      if (q.action == ACT_INSERT) begin
         slot = -1;
         for (int i = 0; i < NBINS; i++)
            if (slot < 0 && bin_valid[i] && bin_tab[i].pt_low == q.bin.pt_low &&
                bin_tab[i].pt_high == q.bin.pt_high && bin_tab[i].eta_low == q.bin.eta_low &&
                bin_tab[i].eta_high == q.bin.eta_high)
               slot = i;
         if (slot < 0 && bin_fill < NBINS) begin
            slot = bin_fill;
            bin_fill++;
         end
         if (slot < 0) begin
            o.status = RES_FULL;
         end else begin
            bin_valid[slot] = 1;
            bin_tab[slot] = q.bin;
         end
         return o;
      end
      hit = -1;
      for (int i = 0; i < NBINS; i++) begin
         if (!bin_valid[i]) continue;
         if (q.query_pt < bin_tab[i].pt_low || q.query_pt >= bin_tab[i].pt_high) continue;
         if ($signed(q.query_eta) < $signed(bin_tab[i].eta_low) ||
             $signed(q.query_eta) >= $signed(bin_tab[i].eta_high)) continue;
         if (hit < 0 || bounds_less(bin_tab[i], bin_tab[hit])) hit = i;
      end
      if (hit < 0) begin
         o.status = RES_MISS;
         sf = 65536;
         er = 0;
      end else begin
         de = clamp_one(bin_tab[hit].data_eff);
         ea = clamp_one(bin_tab[hit].data_err);
         me = clamp_one(bin_tab[hit].mc_eff);
         eb = clamp_one(bin_tab[hit].mc_err);
         a = m_veto ? 65536 - de : de;
         b = m_veto ? 65536 - me : me;
         if (b == 0) begin
            o.status = RES_DIV0;
            sf = 64'hFFFFFF;
            er = 64'hFFFFFF;
         end else begin
            o.status = RES_HIT;
            sf = sat_out(round_div(a << 16, b));
            if (m_emode == ERR_DATA) begin
               er = sat_out(round_div(ea << 16, b));
            end else if (m_emode == ERR_QUAD) begin
               cap = 64'd1 << 28;
               e1 = (ea << 20) / b;
               e2 = ((a * eb) << 20) / (b * b);
               if (e1 > cap) e1 = cap;
               if (e2 > cap) e2 = cap;
               er = sat_out((int_sqrt(e1 * e1 + e2 * e2) + 8) >> 4);
            end else begin
               er = sat_out(round_div((ea * b + a * eb) << 16, b * b));
            end
         end
      end
      sh = longint'(sf) + longint'(er) * longint'(m_syst);
      o.sf = sf[OUT_W-1:0];
      o.er = er[OUT_W-1:0];
      o.sh = sh[SHIFT_W-1:0];
      return o;
   endfunction

   // register write, setup then access
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      case (idx)
         CSR_VETO:  m_veto = val[0];
         CSR_EMODE: m_emode = val[1:0];
         default:   m_syst = $signed(val[3:0]);
      endcase
   endtask

   task automatic set_regs(input bit veto, input logic [1:0] emode, input int syst);
      while (factor_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      csr_write(CSR_VETO, {31'd0, veto});
      csr_write(CSR_EMODE, {30'd0, emode});
      csr_write(CSR_SYST, 32'(syst) & 32'hF);
   endtask

   task automatic send_item(input req_type q, input bit typed, input factor_type e);
      factor_type p;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_if.valid <= 1;
      req_if.action <= q.action;
      req_if.pt_low <= q.bin.pt_low;
      req_if.pt_high <= q.bin.pt_high;
      req_if.eta_low <= q.bin.eta_low;
      req_if.eta_high <= q.bin.eta_high;
      req_if.data_eff <= q.bin.data_eff;
      req_if.data_err <= q.bin.data_err;
      req_if.mc_eff <= q.bin.mc_eff;
      req_if.mc_err <= q.bin.mc_err;
      req_if.query_pt <= q.query_pt;
      req_if.query_eta <= q.query_eta;
      do @(posedge clock); while (!req_if.ready);
      p = compute_factor(q);
      factor_q = {factor_q, (typed ? e : p)};
   endtask

   function automatic logic [EFF_W-1:0] rand_eff();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return ONE_Q16;
         2:       return EFF_W'($urandom_range(0, 131071));
         3:       return EFF_W'($urandom_range(0, 2000));
         default: return EFF_W'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic req_type rand_item();
      req_type q;
      int s, pick;
      q = '0;
      q.action = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         q.bin.pt_low = PT_W'($urandom_range(0, 131071));
         q.bin.pt_high = PT_W'($urandom_range(0, 131071));
         q.bin.eta_low = ETA_W'($urandom_range(0, 16383));
         q.bin.eta_high = ETA_W'($urandom_range(0, 16383));
         q.query_pt = PT_W'($urandom_range(0, 131071));
         q.query_eta = ETA_W'($urandom_range(0, 16383));
      end else if (bin_fill > 0 && (q.action == ACT_LOOKUP || pick < 45)) begin
         s = $urandom_range(0, bin_fill - 1);
         q.bin.pt_low = bin_tab[s].pt_low;
         q.bin.pt_high = bin_tab[s].pt_high;
         q.bin.eta_low = bin_tab[s].eta_low;
         q.bin.eta_high = bin_tab[s].eta_high;
         if (bin_tab[s].pt_high > bin_tab[s].pt_low &&
             $signed(bin_tab[s].eta_high) > $signed(bin_tab[s].eta_low) && pick < 85) begin
            q.query_pt = PT_W'($urandom_range(bin_tab[s].pt_low, bin_tab[s].pt_high - 1));
            q.query_eta = ETA_W'($urandom_range(0, $signed(bin_tab[s].eta_high) -
                                 $signed(bin_tab[s].eta_low) - 1) + $signed(bin_tab[s].eta_low));
         end else begin
            q.query_pt = PT_W'($urandom_range(0, 4000));
            q.query_eta = ETA_W'(int'($urandom_range(0, 9000)) - 4500);
         end
      end else begin
         q.bin.pt_low = PT_W'($urandom_range(0, 3000));
         q.bin.pt_high = PT_W'(q.bin.pt_low + $urandom_range(1, 3000));
         q.bin.eta_low = ETA_W'(int'($urandom_range(0, 8000)) - 4000);
         q.bin.eta_high = ETA_W'($signed(q.bin.eta_low) + int'($urandom_range(1, 4000)));
         q.query_pt = PT_W'($urandom_range(0, 5000));
         q.query_eta = ETA_W'(int'($urandom_range(0, 9000)) - 4500);
      end
      q.bin.data_eff = rand_eff();
      q.bin.data_err = rand_eff();
      q.bin.mc_eff = rand_eff();
      q.bin.mc_err = rand_eff();
      return q;
   endfunction

   // response checker and stall generator
   initial begin
      factor_type e;
      int stall;
      int hold;
      stall = 0;
      hold = 0;
      rsp_if.ready = 0;
      forever begin
         @(posedge clock);
         if (reset) continue;
         if (rsp_if.valid && rsp_if.ready) begin
            if (factor_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected item: status %0d", rsp_if.status);
            end else begin
               e = factor_q.pop_front();
               if (rsp_if.status !== e.status || rsp_if.scale_factor !== e.sf ||
                   rsp_if.scale_error !== e.er || rsp_if.shifted_factor !== e.sh) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: exp %0d %h %h %h got %0d %h %h %h",
                              e.status, e.sf, e.er, e.sh, rsp_if.status,
                              rsp_if.scale_factor, rsp_if.scale_error, rsp_if.shifted_factor);
               end
            end
         end
         if (long_hold) begin
            long_hold = 0;
            hold = 600;
         end
         if (hold > 0) begin
            hold--;
            rsp_if.ready <= 0;
         end else if (stall > 0) begin
            stall--;
            rsp_if.ready <= 0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 18) - 1;
            rsp_if.ready <= 0;
         end else begin
            rsp_if.ready <= 1;
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      row_type rows[$];
      req_type q;
      factor_type z, miss, e;
      bit  vetos[6]  = '{0, 1, 0, 1, 0, 1};
      logic [1:0] emodes[6] = '{ERR_DATA, ERR_QUAD, ERR_QUAD, ERR_LINEAR, 2'd3, ERR_DATA};
      int  shifts[6] = '{4, -4, 1, -1, 2, 0};

      req_if.valid = 0;
      req_if.action = ACT_INSERT;
      req_if.pt_low = '0;
      req_if.pt_high = '0;
      req_if.eta_low = '0;
      req_if.eta_high = '0;
      req_if.data_eff = '0;
      req_if.data_err = '0;
      req_if.mc_eff = '0;
      req_if.mc_err = '0;
      req_if.query_pt = '0;
      req_if.query_eta = '0;
      errors = 0;
      cycles = 0;
      bin_fill = 0;
      m_veto = 0;
      m_emode = ERR_LINEAR;
      m_syst = 0;
      foreach (bin_valid[i]) bin_valid[i] = 0;

      z = '{status: RES_INSERTED, sf: '0, er: '0, sh: '0};
      miss = '{status: RES_MISS, sf: 24'd65536, er: '0, sh: 28'd65536};

      // directed table
      q = '0; q.action = ACT_LOOKUP; q.query_pt = 17'd131071; q.query_eta = 14'h2000;
      rows = {rows, row_type'{q, 1'b1, miss}};
      q = '0; q.bin.pt_high = 17'd131071; q.bin.eta_low = 14'h2000; q.bin.eta_high = 14'h1FFF;
      q.bin.data_eff = ONE_Q16; q.bin.mc_eff = ONE_Q16;
      rows = {rows, row_type'{q, 1'b1, z}};
      q.action = ACT_LOOKUP; q.query_pt = 0; q.query_eta = 14'h2000;
      rows = {rows, row_type'{q, 1'b1, '{RES_HIT, 24'd65536, 24'd0, 28'd65536}}};
      q = '0; q.bin.pt_low = 17'd100; q.bin.pt_high = 17'd50; q.bin.eta_high = 14'd10;
      rows = {rows, row_type'{q, 1'b1, z}};
      q = '0; q.bin.pt_high = 17'd200; q.bin.eta_low = 14'd5; q.bin.eta_high = 14'd5;
      rows = {rows, row_type'{q, 1'b1, z}};
      q = '0; q.bin.pt_high = 17'd16; q.bin.eta_high = 14'd1024;
      q.bin.data_eff = 17'd70000; q.bin.data_err = ONE_Q16; q.bin.mc_eff = '0;
      q.bin.mc_err = 17'h1FFFF;
      rows = {rows, row_type'{q, 1'b1, z}};
      q.action = ACT_LOOKUP; q.query_pt = 0; q.query_eta = 0;
      rows = {rows, row_type'{q, 1'b1, '{RES_DIV0, MAX24, MAX24, 28'hFFFFFF}}};
      q.action = ACT_INSERT; q.bin.data_eff = 17'd32768; q.bin.data_err = 0;
      q.bin.mc_eff = ONE_Q16; q.bin.mc_err = 0;
      rows = {rows, row_type'{q, 1'b1, z}};
      q.action = ACT_LOOKUP; q.query_pt = 17'd15; q.query_eta = 14'd1023;
      rows = {rows, row_type'{q, 1'b1, '{RES_HIT, 24'd32768, 24'd0, 28'd32768}}};
      q.query_pt = 17'd131071; q.query_eta = 14'h1FFF;
      rows = {rows, row_type'{q, 1'b1, miss}};
      q.query_pt = 17'd60; q.query_eta = 14'd5;
      rows = {rows, row_type'{q, 1'b0, z}};
      q = '0; q.bin.pt_low = 17'd16; q.bin.pt_high = 17'd32; q.bin.eta_low = 14'h3FFF;
      q.bin.eta_high = 14'd1; q.bin.data_eff = 17'd1000; q.bin.data_err = 17'd300;
      q.bin.mc_eff = 17'd2000; q.bin.mc_err = 17'd500;
      rows = {rows, row_type'{q, 1'b0, z}};
      q.action = ACT_LOOKUP; q.query_pt = 17'd20; q.query_eta = 14'h3FFF;
      rows = {rows, row_type'{q, 1'b0, z}};
      q.bin.mc_eff = 17'd65535; q.bin.data_eff = 17'd1;
      q.bin.data_err = 17'd65535; q.bin.mc_err = 17'd65535;
      q.action = ACT_INSERT;
      rows = {rows, row_type'{q, 1'b0, z}};
      q.action = ACT_LOOKUP;
      rows = {rows, row_type'{q, 1'b0, z}};

      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (rows[i]) send_item(rows[i].r, rows[i].typed, rows[i].e);
      req_if.valid <= 0;

      for (int ph = 0; ph < 6; ph++) begin
         set_regs(vetos[ph], emodes[ph], shifts[ph]);
         if (ph == 5) idle_on = 0;
         if (ph == 1) long_hold = 1;
         for (int n = 0; n < RAND_ITEMS; n++) begin
            if (ph == 2 && n == 60) begin
               req_if.valid <= 0;
               while (factor_q.size() != 0) @(posedge clock);
            end
            send_item(rand_item(), 0, z);
         end
         req_if.valid <= 0;
      end

      while (factor_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
